// File: design/filled_circle_span_generator_assert.svh
// Assertion macros shared by the span generator modules.
// Each expects clk and rst_n in scope.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define FCSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fcsg_pkg.sv
`timescale 1ns / 1ps

package fcsg_pkg;

  localparam int CX_W       = 12;
  localparam int CY_W       = 12;
  localparam int RAD_W      = 6;
  localparam int COLOR_W    = 32;
  localparam int ROW_W      = 14;
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = 32;
  localparam int PITCH_W    = 16;
  localparam int PROD_W     = ROW_W + PITCH_W + 1;
  localparam int ACC_W      = 11;   // holds r*r and (r+1)^2 for r up to 32
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int BPP_SHIFT  = 2;    // 4 bytes per pixel

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  localparam logic [RAD_W-1:0]   MAX_RADIUS       = 6'd32;
  localparam logic [PITCH_W-1:0] LINE_PITCH_RESET = 16'd2560;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 8'd1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INIT   = 4'b0010,
    S_ROOT   = 4'b0100,
    S_SPAN_B = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic root_step;
    logic emit_a;
    logic emit_b;
    logic next_dy;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic root_more;
    logic last_dy;
    logic slot_free;
  } sts_t;

endpackage

// File: design/fcsg_ctrl.sv
`timescale 1ns / 1ps

module fcsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  fcsg_pkg::sts_t sts,
  output fcsg_pkg::cmd_t cmd
);
  import fcsg_pkg::*;

  `include "filled_circle_span_generator_assert.svh"

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!sts.in_zero) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_more) begin
          cmd.root_step = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit_a = 1'b1;
          state_nxt  = S_SPAN_B;
        end
      end
      S_SPAN_B: begin
        if (sts.slot_free) begin
          cmd.emit_b = 1'b1;
          if (sts.last_dy) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_dy = 1'b1;
            state_nxt   = S_ROOT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `FCSG_ASSERT_NEXT(a_last_to_idle, cmd.emit_b && sts.last_dy, state_r == S_IDLE, "last span did not end circle")
  `FCSG_ASSERT_NEXT(a_zero_stays_idle, cmd.load && sts.in_zero, state_r == S_IDLE, "zero radius left idle")
  `FCSG_ASSERT_NEXT(a_a_then_b, cmd.emit_a, state_r == S_SPAN_B, "span A not followed by span B")

endmodule

// File: design/fcsg_datapath.sv
`timescale 1ns / 1ps

module fcsg_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fcsg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_valid,
  input  logic [fcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcsg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  fcsg_pkg::cmd_t                      cmd,
  output fcsg_pkg::sts_t                      sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fcsg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);
  import fcsg_pkg::*;

  `include "filled_circle_span_generator_assert.svh"

  // config registers
  logic [ADDR_W-1:0]  frame_base_r;
  logic [PITCH_W-1:0] line_pitch_r;

  // circle context
  logic [CX_W-1:0]    cx_r;
  logic [COLOR_W-1:0] color_r;
  logic [RAD_W-1:0]   r_r, dy_r, dx_r;
  logic [ACC_W-1:0]   v_r, sq_r;
  logic [ROW_W-1:0]   row_a_r, row_b_r;
  logic [ADDR_W-1:0]  off_a_r, off_b_r;

  // output register
  logic               out_valid_r;
  logic               out_last_r;
  logic [ROW_W-1:0]   out_row_r, out_x_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] out_fill_r;

  // input unpack
  logic [CX_W-1:0]    in_cx;
  logic [CY_W-1:0]    in_cy;
  logic [RAD_W-1:0]   in_rad, r_sat;
  logic [COLOR_W-1:0] in_color;

  assign in_cx    = in_tdata[CX_W-1:0];
  assign in_cy    = in_tdata[CX_W+CY_W-1:CX_W];
  assign in_rad   = in_tdata[CX_W+CY_W+RAD_W-1:CX_W+CY_W];
  assign in_color = in_tdata[CX_W+CY_W+RAD_W+COLOR_W-1:CX_W+CY_W+RAD_W];
  assign r_sat    = (in_rad > MAX_RADIUS) ? MAX_RADIUS : in_rad;

  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic [CNT_W-1:0]         step_inc, sq_inc;
  logic signed [ROW_W-1:0]  x_start;
  logic [ADDR_W-1:0]        x_term, addr_a, addr_b;

  assign prod_a = PROD_W'($signed(row_a_r)) * PROD_W'($signed({1'b0, line_pitch_r}));
  assign prod_b = PROD_W'($signed(row_b_r)) * PROD_W'($signed({1'b0, line_pitch_r}));

  // v(dy+1) - v(dy) = 2r - 2dy - 1 ; (dx+2)^2 - (dx+1)^2 = 2dx + 3
  assign step_inc = {r_r, 1'b0} - {dy_r, 1'b0} - CNT_W'(1);
  assign sq_inc   = {dx_r, 1'b0} + CNT_W'(3);

  assign x_start = $signed({2'b00, cx_r}) - $signed({{(ROW_W-RAD_W){1'b0}}, dx_r});
  assign x_term  = {{(ADDR_W-ROW_W-BPP_SHIFT){x_start[ROW_W-1]}}, x_start,
                    {BPP_SHIFT{1'b0}}};
  assign addr_a  = frame_base_r + off_a_r + x_term;
  assign addr_b  = frame_base_r + off_b_r + x_term;

  assign sts.in_zero   = (in_rad == '0);
  assign sts.root_more = (sq_r <= v_r);
  assign sts.last_dy   = (dy_r == r_r);
  assign sts.slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      line_pitch_r <= LINE_PITCH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_BASE: frame_base_r <= cfg_data;
        REG_LINE_PITCH: line_pitch_r <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                     out_valid_r <= 1'b0;
    else if (cmd.emit_a || cmd.emit_b) out_valid_r <= 1'b1;
    else if (out_tready)            out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= in_cx;
      color_r <= in_color;
      r_r     <= r_sat;
      dy_r    <= RAD_W'(1);
      dx_r    <= '0;
      sq_r    <= ACC_W'(1);
      v_r     <= {{(ACC_W-RAD_W-1){1'b0}}, r_sat, 1'b0} - ACC_W'(1);
      row_a_r <= {2'b00, in_cy} + {{(ROW_W-RAD_W){1'b0}}, r_sat} - ROW_W'(1);
      row_b_r <= {2'b00, in_cy} - {{(ROW_W-RAD_W){1'b0}}, r_sat} + ROW_W'(1);
    end
    if (cmd.init) begin
      off_a_r <= {{(ADDR_W-PROD_W){prod_a[PROD_W-1]}}, prod_a};
      off_b_r <= {{(ADDR_W-PROD_W){prod_b[PROD_W-1]}}, prod_b};
    end
    if (cmd.root_step) begin
      dx_r <= dx_r + RAD_W'(1);
      sq_r <= sq_r + {{(ACC_W-CNT_W){1'b0}}, sq_inc};
    end
    if (cmd.next_dy) begin
      dy_r    <= dy_r + RAD_W'(1);
      v_r     <= v_r + {{(ACC_W-CNT_W){1'b0}}, step_inc};
      row_a_r <= row_a_r - ROW_W'(1);
      row_b_r <= row_b_r + ROW_W'(1);
      off_a_r <= off_a_r - {{(ADDR_W-PITCH_W){1'b0}}, line_pitch_r};
      off_b_r <= off_b_r + {{(ADDR_W-PITCH_W){1'b0}}, line_pitch_r};
    end
    if (cmd.emit_a || cmd.emit_b) begin
      out_row_r  <= cmd.emit_a ? row_a_r : row_b_r;
      out_addr_r <= cmd.emit_a ? addr_a : addr_b;
      out_last_r <= cmd.emit_b && sts.last_dy;
      out_x_r    <= x_start;
      out_cnt_r  <= {dx_r, 1'b1};
      out_fill_r <= color_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*ROW_W-CNT_W-ADDR_W-COLOR_W){1'b0}},
                       out_fill_r, out_addr_r, out_cnt_r, out_x_r, out_row_r};

  `FCSG_ASSERT_NOW(a_no_overwrite, cmd.emit_a || cmd.emit_b, !out_valid_r || out_tready, "span overwrote a waiting span")
  `FCSG_ASSERT_NOW(a_dx_bound, cmd.emit_a || cmd.emit_b, dx_r <= r_r, "half width exceeds radius")

endmodule

// File: design/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// Channel   Ports                          Transaction
// -------   -----------------------------  --------------------------------------
// in        in_tvalid/in_tready/in_tdata   one circle command
// out       out_tvalid/out_tready/out_*    one horizontal span, tlast on final one
// cfg       cfg_valid/cfg_ready/cfg_*      one register write (0 base, 1 pitch)
//
// A circle of radius r is handled in steps: accept, then form the
// row address offsets (two 14x17 multiplies), then per row pair the half width
// is found by stepping dx up against a shared compare (r steps over the circle)
// and each span is emitted. Radius 0 is accepted and emits nothing.
// A stalled out channel holds the span register and stalls the sequencer at its next span.
// Reset clears control state and loads frame_base 0, line_pitch 2560.

module filled_circle_span_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // center_x[11:0], center_y[23:12], radius[29:24], color[61:30]
  input  logic [fcsg_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // row[13:0], x_start[27:14], pixel_count[34:28], start_address[66:35],
  // fill_value[98:67]
  output logic [fcsg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fcsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcsg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fcsg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  fcsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcsg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: test/fcsg_span_checker.sv
`timescale 1ns / 1ps

// Watches the command, span and register channels, predicts every span of
// each accepted circle and compares the spans in order as they leave the block.
module fcsg_span_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [fcsg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [fcsg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcsg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending_spans,
  output int                               fail_count
);
  import fcsg_pkg::*;

  localparam int REPORT_MAX = 10;

  // Member order matches {out_tlast, out_tdata[98:0]}, lowest field last.
  typedef struct packed {
    logic               is_last;
    logic [COLOR_W-1:0] fill_value;
    logic [ADDR_W-1:0]  start_address;
    logic [CNT_W-1:0]   pixel_count;
    logic [ROW_W-1:0]   x_start;
    logic [ROW_W-1:0]   row;
  } span_t;

  span_t              span_q[$];
  logic [ADDR_W-1:0]  frame_base;
  logic [PITCH_W-1:0] line_pitch;
  int                 errors;
  int                 reported;

  initial begin
    pending_spans = 0;
    fail_count    = 0;
    errors        = 0;
    reported      = 0;
  end

  function automatic span_t make_span(int row, int col, int half,
                                      logic [COLOR_W-1:0] color, logic is_last);
    logic [31:0] row_u;
    logic [31:0] col_u;
    span_t       s;
    row_u = row;
    col_u = col;
    s.row           = row_u[ROW_W-1:0];
    s.x_start       = col_u[ROW_W-1:0];
    s.pixel_count   = CNT_W'(2 * half + 1);
    // two's complement row/column, wraps mod 2^32
    s.start_address = frame_base + row_u * {16'd0, line_pitch} + (col_u << BPP_SHIFT);
    s.fill_value    = color;
    s.is_last       = is_last;
    return s;
  endfunction

  function automatic void predict_circle(logic [IN_TDATA_W-1:0] cmd);
    int cx;
    int cy;
    int r;
    int dy;
    int dx;
    int area;
    logic [COLOR_W-1:0] color;
    cx    = int'(cmd[11:0]);
    cy    = int'(cmd[23:12]);
    r     = int'(cmd[29:24]);
    color = cmd[61:30];
    if (r > int'(MAX_RADIUS)) r = int'(MAX_RADIUS);
    for (dy = 1; dy <= r; dy++) begin
      area = dy * (2 * r - dy);
      dx = 0;
      while ((dx + 1) * (dx + 1) <= area) dx++;
      // lower row first, then the mirrored upper row
      span_q.push_back(make_span(cy + r - dy, cx - dx, dx, color, 1'b0));
      span_q.push_back(make_span(cy - r + dy, cx - dx, dx, color, dy == r));
    end
  endfunction

  always @(posedge clk) begin : monitor
    span_t got;
    span_t want;
    if (!rst_n) begin
      frame_base = '0;
      line_pitch = LINE_PITCH_RESET;
      span_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_BASE) frame_base = cfg_data;
        else if (cfg_index == REG_LINE_PITCH) line_pitch = cfg_data[PITCH_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata[98:0]};
        if (span_q.size() == 0) begin
          errors++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("unexpected span: row %0d x %0d n %0d addr %h fill %h last %b",
                     $signed(got.row), $signed(got.x_start), got.pixel_count,
                     got.start_address, got.fill_value, got.is_last);
          end
        end else begin
          want = span_q.pop_front();
          if (got !== want) begin
            errors++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("span mismatch exp: row %0d x %0d n %0d addr %h fill %h last %b",
                       $signed(want.row), $signed(want.x_start), want.pixel_count,
                       want.start_address, want.fill_value, want.is_last);
              $display("              got: row %0d x %0d n %0d addr %h fill %h last %b",
                       $signed(got.row), $signed(got.x_start), got.pixel_count,
                       got.start_address, got.fill_value, got.is_last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) predict_circle(in_tdata);
    end
    fail_count    <= errors;
    pending_spans <= span_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

// Circle commands in, spans out. The checker beside the block predicts and
// compares; this module only makes traffic and calls the verdict.
module tb;
  import fcsg_pkg::*;

  localparam int MAX_GAP         = 18;
  localparam int HOLD_CYCLES     = 400;   // long out_tready hold-off
  localparam int SETTLE_CYCLES   = 16;    // zero-radius commands finish with no span
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no transaction anywhere
  localparam int PHASE_ITEMS     = 70;
  localparam int RANDOM_PHASES   = 6;

  // indexes that map to no register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int pending_spans;
  int fail_count;

  // gap ceilings per phase, read by both the command and the span side
  int send_gap_max;
  int sink_gap_max;
  // stimulus bumps hold_req, the span side acknowledges via hold_done
  int hold_req;
  int hold_done;
  int quiet_cycles;

  filled_circle_span_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fcsg_span_checker u_span_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_spans (pending_spans),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // At least half the draws are zero so back-to-back runs show up in every phase.
  function automatic int draw_gap(int max_gap);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // One circle command transaction. in_tvalid stays high across back-to-back
  // commands; it only drops when a gap is drawn.
  task automatic send_circle(input logic [11:0] cx, input logic [11:0] cy,
                             input logic [5:0] rad, input logic [31:0] color);
    int gap;
    gap = draw_gap(send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, color, rad, cy, cx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly small radii to keep the run short; a few up to full size and a few
  // above the limit, which must clamp. Some centers sit near the frame edges
  // so rows and columns go negative or past 4095.
  task automatic send_random_circle();
    logic [11:0] cx;
    logic [11:0] cy;
    logic [5:0]  rad;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      rad = 6'($urandom_range(0, 8));
    else if (pick < 95) rad = 6'($urandom_range(9, 32));
    else                rad = 6'($urandom_range(33, 63));
    cx = 12'($urandom);
    cy = 12'($urandom);
    case ($urandom_range(0, 7))
      0: cx = 12'($urandom_range(0, 40));
      1: cy = 12'($urandom_range(0, 40));
      2: cx = 12'(4095 - $urandom_range(0, 40));
      3: cy = 12'(4095 - $urandom_range(0, 40));
      default: ;
    endcase
    send_circle(cx, cy, rad, $urandom);
  endtask

  // Register write transaction; valid drops for one cycle after each.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering commands until every predicted span has come out, then give
  // a trailing zero-radius command time to retire.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_spans != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Span side: random ready gaps, or one long hold-off when asked for.
  initial begin : span_sink
    int wait_len;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req != hold_done) begin
        wait_len = HOLD_CYCLES;
        hold_done++;
      end else begin
        wait_len = draw_gap(sink_gap_max);
      end
      if (wait_len > 0) begin
        out_tready <= 1'b0;
        repeat (wait_len) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    send_gap_max = 0;
    sink_gap_max = 0;
    hold_req     = 0;
    hold_done    = 0;
    quiet_cycles = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: zero radius, the smallest radii,
    // full radius at both frame corners (negative rows and columns, wrapped
    // addresses), radius above the limit and all radius bits set.
    send_circle(12'd100, 12'd100, 6'd0,  32'h0000_0000);
    send_circle(12'd0,   12'd0,   6'd0,  32'hFFFF_FFFF);
    send_circle(12'd10,  12'd20,  6'd1,  32'h1234_5678);
    send_circle(12'd300, 12'd200, 6'd2,  32'h8000_0001);
    send_circle(12'd64,  12'd64,  6'd3,  32'hDEAD_BEEF);
    send_circle(12'd0,   12'd0,   6'd32, 32'hFFFF_FFFF);
    send_circle(12'hFFF, 12'hFFF, 6'd32, 32'h0000_0000);
    send_circle(12'hAAA, 12'h555, 6'd33, 32'hAAAA_AAAA);
    send_circle(12'h555, 12'hAAA, 6'd63, 32'h5555_5555);
    send_circle(12'd2048, 12'd2048, 6'd31, $urandom);
    send_circle(12'd1,   12'hFFE, 6'd5,  $urandom);
    send_circle(12'hFFF, 12'd0,   6'd16, $urandom);
    wait_idle();

    // Register extremes; unmapped indexes in between must change nothing.
    cfg_write(REG_FRAME_BASE, 32'hFFFF_FFFF);
    cfg_write(REG_LINE_PITCH, 32'h0000_FFFF);
    cfg_write(REG_UNMAPPED_LO, $urandom);
    cfg_write(REG_UNMAPPED_HI, $urandom);
    send_circle(12'd0,   12'd0,   6'd32, 32'hCAFE_F00D);
    send_circle(12'hFFF, 12'hFFF, 6'd32, 32'h0F0F_0F0F);
    send_circle(12'd2048, 12'd100, 6'd7, $urandom);
    wait_idle();
    cfg_write(REG_FRAME_BASE, 32'h0000_0000);
    cfg_write(REG_LINE_PITCH, 32'h0000_0000);
    send_circle(12'd5,   12'd5,   6'd9,  $urandom);
    send_circle(12'd4000, 12'd30, 6'd4,  $urandom);

    // Random phases, each under its own register setting and gap profile.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          cfg_write(REG_FRAME_BASE, $urandom);
          cfg_write(REG_LINE_PITCH, $urandom_range(0, 65535));
          send_gap_max = 0;
          sink_gap_max = 0;
        end
        1: begin
          cfg_write(REG_FRAME_BASE, 32'h0000_0000);
          cfg_write(REG_LINE_PITCH, 32'h0000_FFFF);
          send_gap_max = MAX_GAP;
          sink_gap_max = 0;
        end
        2: begin
          // commands keep coming while the span side sits on a long hold,
          // so the block backs up into in_tready
          cfg_write(REG_FRAME_BASE, 32'hFFFF_FFFF);
          cfg_write(REG_LINE_PITCH, 32'h0000_0000);
          send_gap_max = 0;
          sink_gap_max = MAX_GAP;
          hold_req++;
        end
        3: begin
          cfg_write(REG_FRAME_BASE, $urandom);
          cfg_write(REG_LINE_PITCH, $urandom_range(0, 65535));
          cfg_write(REG_UNMAPPED_LO, $urandom);
          send_gap_max = MAX_GAP;
          sink_gap_max = MAX_GAP;
        end
        4: begin
          cfg_write(REG_FRAME_BASE, 32'h8000_0000);
          cfg_write(REG_LINE_PITCH, 32'h0000_0001);
          send_gap_max = 5;
          sink_gap_max = MAX_GAP;
        end
        default: begin
          cfg_write(REG_FRAME_BASE, 32'h0000_0000);
          cfg_write(REG_LINE_PITCH, 32'(LINE_PITCH_RESET));
          send_gap_max = MAX_GAP;
          sink_gap_max = 3;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_circle();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
